FILE: rtl/qpc_pkg.sv
// Shared types, constants and helper functions of the quintic profile checker.
// Holds the Horner micro-op program, the queue item and result structs.
// No dependencies; every other file imports this package.
package qpc_pkg;

    // Field and register widths
    localparam int TIME_W    = 32;
    localparam int COEF_W    = 64;
    localparam int OUT_W     = 48;
    localparam int OUT_FRAC  = 32;
    localparam int NUM_COEF  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 4 * OUT_W;

    // Default fixed-point formats
    localparam int TIME_FRAC_BITS_DEF = 24;
    localparam int COEF_FRAC_BITS_DEF = 48;

    // Input queue
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_T1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_T2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_T3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_T4    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_T5    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JERK_LIMIT  = 3'd7;

    // Saturation bounds
    localparam logic signed [COEF_W-1:0] COEF_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_POS_MAG = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAG = 48'h8000_0000_0000;

    typedef logic signed [COEF_W-1:0] qpc_coef_t;

    // Coefficient selects (array slot of c1..c5)
    localparam logic [2:0] CS_T1 = 3'd0;
    localparam logic [2:0] CS_T2 = 3'd1;
    localparam logic [2:0] CS_T3 = 3'd2;
    localparam logic [2:0] CS_T4 = 3'd3;
    localparam logic [2:0] CS_T5 = 3'd4;

    // Derivative scale factors
    localparam logic [5:0] K0  = 6'd0;
    localparam logic [5:0] K1  = 6'd1;
    localparam logic [5:0] K2  = 6'd2;
    localparam logic [5:0] K3  = 6'd3;
    localparam logic [5:0] K4  = 6'd4;
    localparam logic [5:0] K5  = 6'd5;
    localparam logic [5:0] K6  = 6'd6;     // 3*2*1
    localparam logic [5:0] K12 = 6'd12;
    localparam logic [5:0] K20 = 6'd20;    // 5*4
    localparam logic [5:0] K24 = 6'd24;    // 4*3*2
    localparam logic [5:0] K60 = 6'd60;    // 5*4*3

    // Quantity codes
    localparam logic [1:0] QTY_DISP = 2'd0;
    localparam logic [1:0] QTY_VEL  = 2'd1;
    localparam logic [1:0] QTY_ACC  = 2'd2;
    localparam logic [1:0] QTY_JERK = 2'd3;

    localparam int PROG_LEN = 18;
    localparam int PC_W     = 5;

    // One Horner micro-op
    typedef struct packed {
        logic       load;      // start a chain: acc = k*c
        logic [2:0] coef_sel;
        logic [5:0] scale;
        logic       last;      // chain ends after this op
        logic [1:0] quant;
    } qpc_op_t;

    // Queued input item
    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic              first_sample;
        logic              last_sample;
    } qpc_item_t;

    // Evaluated sample passed to the checker
    typedef struct packed {
        logic signed [OUT_W-1:0] displacement;
        logic signed [OUT_W-1:0] velocity;
        logic signed [OUT_W-1:0] acceleration;
        logic signed [OUT_W-1:0] jerk;
        logic [OUT_W-1:0]        speed_mag;
        logic [OUT_W-1:0]        accel_mag;
        logic [OUT_W-1:0]        jerk_mag;
        logic                    first_sample;
        logic                    last_sample;
    } qpc_result_t;

    function automatic qpc_op_t mk_op(input logic load, input logic [2:0] sel,
                                      input logic [5:0] scale, input logic last,
                                      input logic [1:0] quant);
        qpc_op_t op;
        op.load     = load;
        op.coef_sel = sel;
        op.scale    = scale;
        op.last     = last;
        op.quant    = quant;
        return op;
    endfunction

    // Horner program: displacement, velocity, acceleration, jerk
    function automatic qpc_op_t prog_op(input logic [PC_W-1:0] pc);
        qpc_op_t op;
        unique case (pc)
            5'd0:    op = mk_op(1'b1, CS_T5, K1,  1'b0, QTY_DISP);
            5'd1:    op = mk_op(1'b0, CS_T4, K1,  1'b0, QTY_DISP);
            5'd2:    op = mk_op(1'b0, CS_T3, K1,  1'b0, QTY_DISP);
            5'd3:    op = mk_op(1'b0, CS_T2, K1,  1'b0, QTY_DISP);
            5'd4:    op = mk_op(1'b0, CS_T1, K1,  1'b0, QTY_DISP);
            // extra multiply by t with nothing added
            5'd5:    op = mk_op(1'b0, CS_T1, K0,  1'b1, QTY_DISP);
            5'd6:    op = mk_op(1'b1, CS_T5, K5,  1'b0, QTY_VEL);
            5'd7:    op = mk_op(1'b0, CS_T4, K4,  1'b0, QTY_VEL);
            5'd8:    op = mk_op(1'b0, CS_T3, K3,  1'b0, QTY_VEL);
            5'd9:    op = mk_op(1'b0, CS_T2, K2,  1'b0, QTY_VEL);
            5'd10:   op = mk_op(1'b0, CS_T1, K1,  1'b1, QTY_VEL);
            5'd11:   op = mk_op(1'b1, CS_T5, K20, 1'b0, QTY_ACC);
            5'd12:   op = mk_op(1'b0, CS_T4, K12, 1'b0, QTY_ACC);
            5'd13:   op = mk_op(1'b0, CS_T3, K6,  1'b0, QTY_ACC);
            5'd14:   op = mk_op(1'b0, CS_T2, K2,  1'b1, QTY_ACC);
            5'd15:   op = mk_op(1'b1, CS_T5, K60, 1'b0, QTY_JERK);
            5'd16:   op = mk_op(1'b0, CS_T4, K24, 1'b0, QTY_JERK);
            5'd17:   op = mk_op(1'b0, CS_T3, K6,  1'b1, QTY_JERK);
            default: op = mk_op(1'b0, CS_T1, K0,  1'b1, QTY_JERK);
        endcase
        return op;
    endfunction

    // k*c saturated to the signed 64-bit range
    function automatic qpc_coef_t sat_scale(input qpc_coef_t c, input logic [5:0] k);
        logic signed [70:0] p;
        p = 71'(c) * $signed({65'd0, k});
        if (p[70:63] != {8{p[63]}}) begin
            return p[70] ? COEF_MIN : COEF_MAX;
        end
        return $signed(p[63:0]);
    endfunction

endpackage

FILE: rtl/qpc_front.sv
// Front end of the quintic profile checker: input stream handshake and a
// short item queue toward the evaluator. Depends on qpc_pkg.
module qpc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [qpc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    input  logic                               s_axis_tuser,
    output logic                               item_valid,
    output qpc_pkg::qpc_item_t                 item,
    input  logic                               item_ready
);
    import qpc_pkg::*;

    qpc_item_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    qpc_item_t             in_item;
    logic                  push, pop;

    // sort the stream word into item fields
    always_comb begin
        in_item.sample_time  = s_axis_tdata[TIME_W-1:0];
        in_item.first_sample = s_axis_tuser;
        in_item.last_sample  = s_axis_tlast;
    end

    assign s_axis_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign item_valid    = (count_reg != '0);
    assign item          = queue_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = item_valid && item_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/qpc_eval.sv
// Horner evaluator of the quintic profile checker: sequencer plus one shared
// 32x32 multiplier computing displacement and the three derivatives.
// Depends on qpc_pkg.
module qpc_eval #(
    parameter int TIME_FRAC_BITS = qpc_pkg::TIME_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS = qpc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qpc_pkg::qpc_coef_t    coeff [qpc_pkg::NUM_COEF],
    input  logic                  item_valid,
    input  qpc_pkg::qpc_item_t    item,
    output logic                  item_ready,
    output logic                  res_valid,
    output qpc_pkg::qpc_result_t  res,
    input  logic                  res_ready
);
    import qpc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OP    = 4'd1;
    localparam logic [3:0] ST_MULLO = 4'd2;
    localparam logic [3:0] ST_MULHI = 4'd3;
    localparam logic [3:0] ST_SHIFT = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_CMAG  = 4'd6;
    localparam logic [3:0] ST_CONV  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    // output format conversion shifts
    localparam int SHR = (COEF_FRAC_BITS >= OUT_FRAC) ? COEF_FRAC_BITS - OUT_FRAC : 0;
    localparam int SHL = (COEF_FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - COEF_FRAC_BITS : 0;
    localparam logic [COEF_W-1:0] SHL_LIMIT = 64'd1 << (OUT_W - 1 - SHL);

    logic [3:0]          state_reg, state_next;
    logic [PC_W-1:0]     pc_reg;
    logic [TIME_W-1:0]   t_reg;
    qpc_coef_t           acc_reg, coef_reg;
    logic [COEF_W-1:0]   mag_reg, qmag_reg;
    logic                neg_reg;
    logic [63:0]         prod_lo_reg, prod_hi_reg;
    qpc_result_t         res_reg;

    qpc_op_t             op;
    qpc_coef_t           scaled;
    logic [COEF_W-1:0]   acc_mag;
    logic [31:0]         mul_a;
    logic [63:0]         prod;
    logic [95:0]         full, shifted;
    logic [COEF_W-1:0]   qmag;
    logic [COEF_W-1:0]   bm;
    logic [COEF_W:0]     addend, sum65;
    qpc_coef_t           add_res;
    logic [COEF_W-1:0]   m_sh;
    logic [OUT_W-1:0]    mag_out;
    logic signed [OUT_W-1:0] val_out;

    assign op         = prog_op(pc_reg);
    assign scaled     = sat_scale(coeff[op.coef_sel], op.scale);
    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = res_reg;

    // magnitude of the accumulator
    assign acc_mag = acc_reg[COEF_W-1] ? (~$unsigned(acc_reg) + 64'd1) : $unsigned(acc_reg);

    // shared multiplier: low then high half of the magnitude times t
    assign mul_a = (state_reg == ST_MULHI) ? mag_reg[63:32] : mag_reg[31:0];
    assign prod  = {32'd0, mul_a} * {32'd0, t_reg};

    // assemble the 96-bit product, drop time fraction, saturate magnitude
    always_comb begin
        full    = {32'd0, prod_lo_reg} + {prod_hi_reg, 32'd0};
        shifted = full >> TIME_FRAC_BITS;
        qmag    = (|shifted[95:64]) ? '1 : shifted[63:0];
    end

    // signed product plus coefficient, one adder with carry-in for negation
    always_comb begin
        if (neg_reg) begin
            bm = qmag_reg[COEF_W-1] ? 64'h8000_0000_0000_0000 : qmag_reg;
        end else begin
            bm = qmag_reg[COEF_W-1] ? 64'h7FFF_FFFF_FFFF_FFFF : qmag_reg;
        end
        addend = neg_reg ? ~{1'b0, bm} : {1'b0, bm};
        sum65  = {coef_reg[COEF_W-1], $unsigned(coef_reg)} + addend + 65'(neg_reg);
        if (sum65[COEF_W] != sum65[COEF_W-1]) begin
            add_res = sum65[COEF_W] ? COEF_MIN : COEF_MAX;
        end else begin
            add_res = $signed(sum65[COEF_W-1:0]);
        end
    end

    // conversion to Q16.32 with saturation to 48 bits
    always_comb begin
        if (SHL == 0) begin
            m_sh = mag_reg >> SHR;
        end else begin
            m_sh = (mag_reg > SHL_LIMIT) ? 64'(OUT_NEG_MAG) : (mag_reg << SHL);
        end
        if (neg_reg) begin
            mag_out = (m_sh > 64'(OUT_NEG_MAG)) ? OUT_NEG_MAG : m_sh[OUT_W-1:0];
        end else begin
            mag_out = (m_sh > 64'(OUT_POS_MAG)) ? OUT_POS_MAG : m_sh[OUT_W-1:0];
        end
        val_out = $signed(neg_reg ? (~mag_out + 48'd1) : mag_out);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_valid) state_next = ST_OP;
            ST_OP:    state_next = op.load ? ST_OP : ST_MULLO;
            ST_MULLO: state_next = ST_MULHI;
            ST_MULHI: state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_ADD;
            ST_ADD:   state_next = op.last ? ST_CMAG : ST_OP;
            ST_CMAG:  state_next = ST_CONV;
            ST_CONV:  state_next = (op.quant == QTY_JERK) ? ST_DONE : ST_OP;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                pc_reg <= '0;
            end else if ((state_reg == ST_OP && op.load) ||
                         (state_reg == ST_ADD && !op.last) ||
                         (state_reg == ST_CONV && op.quant != QTY_JERK)) begin
                pc_reg <= pc_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    t_reg                <= item.sample_time;
                    res_reg.first_sample <= item.first_sample;
                    res_reg.last_sample  <= item.last_sample;
                end
            end
            ST_OP: begin
                coef_reg <= scaled;
                mag_reg  <= acc_mag;
                neg_reg  <= acc_reg[COEF_W-1];
                if (op.load) begin
                    acc_reg <= scaled;
                end
            end
            ST_MULLO: prod_lo_reg <= prod;
            ST_MULHI: prod_hi_reg <= prod;
            ST_SHIFT: qmag_reg    <= qmag;
            ST_ADD:   acc_reg     <= add_res;
            ST_CMAG: begin
                mag_reg <= acc_mag;
                neg_reg <= acc_reg[COEF_W-1];
            end
            ST_CONV: begin
                unique case (op.quant)
                    QTY_DISP: res_reg.displacement <= val_out;
                    QTY_VEL: begin
                        res_reg.velocity  <= val_out;
                        res_reg.speed_mag <= mag_out;
                    end
                    QTY_ACC: begin
                        res_reg.acceleration <= val_out;
                        res_reg.accel_mag    <= mag_out;
                    end
                    QTY_JERK: begin
                        res_reg.jerk     <= val_out;
                        res_reg.jerk_mag <= mag_out;
                    end
                endcase
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/qpc_check.sv
// Peak tracker and limit check of the quintic profile checker, with the
// registered result stream. Depends on qpc_pkg.
module qpc_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [qpc_pkg::OUT_W-1:0]          speed_limit,
    input  logic [qpc_pkg::OUT_W-1:0]          accel_limit,
    input  logic [qpc_pkg::OUT_W-1:0]          jerk_limit,
    input  logic                               res_valid,
    input  qpc_pkg::qpc_result_t               res,
    output logic                               res_ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [qpc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser
);
    import qpc_pkg::*;

    logic [OUT_W-1:0] peak_speed_reg, peak_accel_reg, peak_jerk_reg;
    logic [OUT_W-1:0] peak_speed_next, peak_accel_next, peak_jerk_next;
    logic [OUT_W-1:0] base_speed, base_accel, base_jerk;
    logic             hold_valid_reg;
    qpc_result_t      hold_reg;
    logic             out_valid_reg;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic             out_last_reg, out_within_reg;
    logic             accept, move, in_limits;

    assign res_ready = !hold_valid_reg;
    assign accept    = res_valid && res_ready;
    assign move      = hold_valid_reg && (!out_valid_reg || m_axis_tready);

    // running maxima of magnitudes, restarted on the first sample
    always_comb begin
        base_speed = res.first_sample ? '0 : peak_speed_reg;
        base_accel = res.first_sample ? '0 : peak_accel_reg;
        base_jerk  = res.first_sample ? '0 : peak_jerk_reg;
        peak_speed_next = (res.speed_mag > base_speed) ? res.speed_mag : base_speed;
        peak_accel_next = (res.accel_mag > base_accel) ? res.accel_mag : base_accel;
        peak_jerk_next  = (res.jerk_mag  > base_jerk)  ? res.jerk_mag  : base_jerk;
    end

    // limit check on the updated peaks
    assign in_limits = (peak_speed_reg <= speed_limit) &&
                       (peak_accel_reg <= accel_limit) &&
                       (peak_jerk_reg  <= jerk_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_speed_reg <= '0;
            peak_accel_reg <= '0;
            peak_jerk_reg  <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                peak_speed_reg <= peak_speed_next;
                peak_accel_reg <= peak_accel_next;
                peak_jerk_reg  <= peak_jerk_next;
                hold_valid_reg <= 1'b1;
            end else if (move) begin
                hold_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= res;
        end
        if (move) begin
            out_data_reg   <= {hold_reg.jerk, hold_reg.acceleration,
                               hold_reg.velocity, hold_reg.displacement};
            out_last_reg   <= hold_reg.last_sample;
            out_within_reg <= in_limits;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_within_reg;

endmodule

FILE: rtl/quintic_profile_check_top.sv
// Top level of the quintic profile checker: configuration registers and the
// front queue, Horner evaluator and peak checker. Depends on qpc_pkg,
// qpc_front, qpc_eval and qpc_check.
//
// Usage:
//   Input stream: one word per time sample, tdata = sample_time (Q8.24),
//   tuser = first_sample (restarts the peaks), tlast = last_sample.
//   Result stream: tdata = displacement, velocity, acceleration, jerk
//   (Q16.32 each, 48 bits), tlast = profile_done, tuser = within_limits.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (coeff_t1..coeff_t5, speed_limit, accel_limit, jerk_limit);
//   write only while no sample is in flight.
//   Evaluation: for each sample the evaluator accepts the input word, issues
//   the 18 micro-ops, runs 14 multiply-by-t steps on the shared 32x32
//   multiplier (low half, high half, shift, saturating add), makes 4 output
//   conversions and hands the result off. It takes no new sample until
//   its result has been handed off.
//   A 4-entry queue takes samples while the evaluator is busy. When the
//   receiver stalls, one result waits in the output register, one in the
//   hold register, then the evaluator and finally the input side back up.
//   Reset clears registers, peaks, queue and all valid flags.
module quintic_profile_check_top #(
    parameter int TIME_FRAC_BITS = qpc_pkg::TIME_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS = qpc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qpc_pkg::TDATA_IN_W-1:0]   s_axis_tdata,   // [31:0] sample_time
    input  logic                             s_axis_tlast,   // last_sample
    input  logic                             s_axis_tuser,   // first_sample
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [47:0] displacement, [95:48] velocity, [143:96] acceleration, [191:144] jerk
    output logic [qpc_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,   // profile_done
    output logic                             m_axis_tuser,   // within_limits
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qpc_pkg::COEF_W-1:0]       cfg_wdata
);
    import qpc_pkg::*;

    qpc_coef_t         coeff_reg [NUM_COEF];
    logic [OUT_W-1:0]  speed_limit_reg, accel_limit_reg, jerk_limit_reg;

    logic              item_valid, item_ready;
    qpc_item_t         item;
    logic              res_valid, res_ready;
    qpc_result_t       res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coeff_reg[i] <= '0;
            end
            speed_limit_reg <= '0;
            accel_limit_reg <= '0;
            jerk_limit_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEFF_T1:    coeff_reg[0]    <= $signed(cfg_wdata);
                REG_COEFF_T2:    coeff_reg[1]    <= $signed(cfg_wdata);
                REG_COEFF_T3:    coeff_reg[2]    <= $signed(cfg_wdata);
                REG_COEFF_T4:    coeff_reg[3]    <= $signed(cfg_wdata);
                REG_COEFF_T5:    coeff_reg[4]    <= $signed(cfg_wdata);
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[OUT_W-1:0];
                REG_ACCEL_LIMIT: accel_limit_reg <= cfg_wdata[OUT_W-1:0];
                REG_JERK_LIMIT:  jerk_limit_reg  <= cfg_wdata[OUT_W-1:0];
            endcase
        end
    end

    qpc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_ready    (item_ready)
    );

    qpc_eval #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coeff      (coeff_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    qpc_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .speed_limit   (speed_limit_reg),
        .accel_limit   (accel_limit_reg),
        .jerk_limit    (jerk_limit_reg),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
